// File: hw/rtl/scp_pkg.sv
package scp_pkg;

    localparam int SCP_NUM_SUB   = 6;
    localparam int SCP_NUM_MASKS = 64;
    localparam int SCP_QDEPTH    = 2;
    localparam int SCP_SUM_W     = 11;  // six 8-bit channel values
    localparam int SCP_DIST_W    = 18;  // three squared 8-bit differences
    localparam int SCP_ERR_W     = 21;  // six subpixel distances
    localparam int SCP_RECIP_W   = 17;
    localparam int SCP_RECIP_SH  = 16;

    typedef struct packed {
        logic [23:0] px0_rgb;
        logic [23:0] px1_rgb;
        logic [23:0] px2_rgb;
        logic [23:0] px3_rgb;
        logic [23:0] px4_rgb;
        logic [23:0] px5_rgb;
        logic [5:0]  opaque_flags;
        logic [23:0] under_color;
    } t_scp_in;

    typedef struct packed {
        logic [5:0]  glyph_mask;
        logic [23:0] fg_color;
        logic [23:0] bg_color;
    } t_scp_out;

    // resolved subpixel colors of one cell, index = subpixel number
    typedef logic [SCP_NUM_SUB-1:0][23:0] t_scp_cell;

    typedef struct packed {
        logic full;
        logic empty;
    } t_scp_qstat;

    // ceil(2^16 / n); exact floor division for sums up to 1530 and n in 1..6
    function automatic logic [SCP_RECIP_W-1:0] scp_recip(input logic [2:0] n);
        logic [SCP_RECIP_W-1:0] r;
        r = '0;
        case (n)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21846;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13108;
            3'd6:    r = 17'd10923;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/sextant_two_color_partition.sv
// Channel   Dir  Handshake               Payload
// in        in   i_in_valid / o_in_stall   i_in  (scp_pkg::t_scp_in)
// out       out  o_out_valid / i_out_stall o_out (scp_pkg::t_scp_out)
//
// Each request with any opaque subpixel is searched over all 64 masks in the back
// end, one mask scored per cycle by the mask sequencer while the output is not stalled;
// consecutive cells issue back to back, and each score passes stages 1 to 4 to the output register.
// Requests with no opaque subpixel are dropped by the front end at once.
// Reset (i_rst_n low, synchronous) empties the queue and the pipeline.
// A stalled result freezes the whole back end; the queue keeps taking requests
// until it is full, then o_in_stall rises.
module sextant_two_color_partition #(
    parameter int QDEPTH = scp_pkg::SCP_QDEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  scp_pkg::t_scp_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output scp_pkg::t_scp_out o_out
);
    import scp_pkg::*;

    logic       w_accept;
    logic       w_push;
    logic       w_pop;
    t_scp_cell  w_in_cell;
    t_scp_cell  w_q_cell;
    t_scp_qstat w_qstat;

    // front is free while the queue has room
    assign o_in_stall = w_qstat.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // classify: background substitution, drop of fully transparent cells
    scp_front u_front (
        .i_in     (i_in),
        .i_accept (w_accept),
        .o_push   (w_push),
        .o_cell   (w_in_cell)
    );

    // short queue decoupling the front from the mask search
    scp_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cell  (w_in_cell),
        .i_pop   (w_pop),
        .o_cell  (w_q_cell),
        .o_stat  (w_qstat)
    );

    // 64-mask search: sums, means, distances, total, best-keep
    scp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!w_qstat.empty),
        .i_q_cell    (w_q_cell),
        .o_q_pop     (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // the front never writes a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_qstat.full))
        else $error("push into full queue");

    // back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_qstat.empty))
        else $error("pop from empty queue");

    // the all-foreground mask ties with mask zero and is never chosen
    a_no_full_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.glyph_mask != 6'h3F))
        else $error("all-foreground mask selected");

    // mask zero has no foreground; fg copies bg
    a_mask0_colors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.glyph_mask == '0)) |-> (o_out.fg_color == o_out.bg_color))
        else $error("mask zero with differing colors");

endmodule

// File: hw/rtl/scp_front.sv
module scp_front (
    input  scp_pkg::t_scp_in   i_in,
    input  logic               i_accept,
    output logic               o_push,
    output scp_pkg::t_scp_cell o_cell
);
    import scp_pkg::*;

    logic [SCP_NUM_SUB-1:0][23:0] w_px;

    assign w_px = {i_in.px5_rgb, i_in.px4_rgb, i_in.px3_rgb,
                   i_in.px2_rgb, i_in.px1_rgb, i_in.px0_rgb};

    // a cell with nothing opaque produces no result and is dropped here
    assign o_push = i_accept && (i_in.opaque_flags != '0);

    always_comb begin
        for (int i = 0; i < SCP_NUM_SUB; i++) begin
            o_cell[i] = i_in.opaque_flags[i] ? w_px[i] : i_in.under_color;
        end
    end

endmodule

// File: hw/rtl/scp_fifo.sv
module scp_fifo #(
    parameter int DEPTH = scp_pkg::SCP_QDEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  scp_pkg::t_scp_cell  i_cell,
    input  logic                i_pop,
    output scp_pkg::t_scp_cell  o_cell,
    output scp_pkg::t_scp_qstat o_stat
);
    import scp_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_scp_cell     r_mem [DEPTH];
    logic [IW-1:0] r_wr, n_wr;
    logic [IW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_cell       = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == IW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == IW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cell;
        end
    end

endmodule

// File: hw/rtl/scp_back.sv
module scp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  scp_pkg::t_scp_cell i_q_cell,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output scp_pkg::t_scp_out  o_out
);
    import scp_pkg::*;

    localparam logic [5:0] LAST_MASK = 6'(SCP_NUM_MASKS - 1);

    logic w_en;

    // stage 0: mask sequencer
    logic       r_busy;
    logic [5:0] r_mask;
    t_scp_cell  r_col;

    // stage 1: group sums
    logic                 r1_v, r1_first, r1_last;
    logic [5:0]           r1_mask;
    t_scp_cell            r1_col;
    logic [2:0][SCP_SUM_W-1:0] r1_fs, r1_bs;
    logic [2:0]           r1_nf;
    logic [2:0][SCP_SUM_W-1:0] n1_fs, n1_ts;
    logic [2:0]           n1_nf;

    // stage 2: group means
    logic        r2_v, r2_first, r2_last;
    logic [5:0]  r2_mask;
    t_scp_cell   r2_col;
    logic [23:0] r2_fg, r2_bg;
    logic [23:0] n2_fg, n2_bg;
    logic [2:0]  w2_nb;

    // stage 3: per-subpixel distance
    logic        r3_v, r3_first, r3_last;
    logic [5:0]  r3_mask;
    logic [23:0] r3_fg, r3_bg;
    logic [SCP_NUM_SUB-1:0][SCP_DIST_W-1:0] r3_d, n3_d;

    // stage 4: total error
    logic        r4_v, r4_first, r4_last;
    logic [5:0]  r4_mask;
    logic [23:0] r4_fg, r4_bg;
    logic [SCP_ERR_W-1:0] r4_err, n4_err;

    // running best
    logic [SCP_ERR_W-1:0] r_best_err;
    t_scp_out             r_best;
    logic                 w_better;
    t_scp_out             w_cand;

    logic     r_out_valid;
    t_scp_out r_out;

    assign w_en        = !r_out_valid || !i_out_stall;
    assign o_q_pop     = w_en && i_q_valid && (!r_busy || (r_mask == LAST_MASK));
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_en) begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (r_mask == LAST_MASK) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (o_q_pop) begin
                r_mask <= '0;
                r_col  <= i_q_cell;
            end else if (r_busy) begin
                r_mask <= r_mask + 1'b1;
            end
        end
    end

    always_comb begin
        n1_fs = '0;
        n1_ts = '0;
        n1_nf = '0;
        for (int i = 0; i < SCP_NUM_SUB; i++) begin
            for (int c = 0; c < 3; c++) begin
                n1_ts[c] = n1_ts[c] + SCP_SUM_W'(r_col[i][8*c +: 8]);
                if (r_mask[i]) begin
                    n1_fs[c] = n1_fs[c] + SCP_SUM_W'(r_col[i][8*c +: 8]);
                end
            end
            n1_nf = n1_nf + 3'(r_mask[i]);
        end
    end

    assign w2_nb = 3'(SCP_NUM_SUB) - r1_nf;

    always_comb begin
        logic [27:0] pf, pb;
        n2_fg = '0;
        n2_bg = '0;
        for (int c = 0; c < 3; c++) begin
            pf = 28'(r1_fs[c]) * 28'(scp_recip(r1_nf));
            pb = 28'(r1_bs[c]) * 28'(scp_recip(w2_nb));
            n2_fg[8*c +: 8] = pf[SCP_RECIP_SH +: 8];
            n2_bg[8*c +: 8] = pb[SCP_RECIP_SH +: 8];
        end
        // empty group copies the other mean; it never enters the score
        if (r1_nf == '0) begin
            n2_fg = n2_bg;
        end
        if (w2_nb == '0) begin
            n2_bg = n2_fg;
        end
    end

    always_comb begin
        logic [23:0] ref_c;
        logic [7:0]  x, y, d;
        n3_d = '0;
        for (int i = 0; i < SCP_NUM_SUB; i++) begin
            ref_c = r2_mask[i] ? r2_fg : r2_bg;
            for (int c = 0; c < 3; c++) begin
                x = r2_col[i][8*c +: 8];
                y = ref_c[8*c +: 8];
                d = (x > y) ? x - y : y - x;
                n3_d[i] = n3_d[i] + SCP_DIST_W'(16'(d) * 16'(d));
            end
        end
    end

    always_comb begin
        n4_err = '0;
        for (int i = 0; i < SCP_NUM_SUB; i++) begin
            n4_err = n4_err + SCP_ERR_W'(r3_d[i]);
        end
    end

    assign w_cand   = '{glyph_mask: r4_mask, fg_color: r4_fg, bg_color: r4_bg};
    assign w_better = r4_first || (r4_err < r_best_err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_v        <= r_busy;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r_out_valid <= r4_v && r4_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_first <= (r_mask == '0);
            r1_last  <= (r_mask == LAST_MASK);
            r1_mask  <= r_mask;
            r1_col   <= r_col;
            r1_fs    <= n1_fs;
            for (int c = 0; c < 3; c++) begin
                r1_bs[c] <= n1_ts[c] - n1_fs[c];
            end
            r1_nf    <= n1_nf;

            r2_first <= r1_first;
            r2_last  <= r1_last;
            r2_mask  <= r1_mask;
            r2_col   <= r1_col;
            r2_fg    <= n2_fg;
            r2_bg    <= n2_bg;

            r3_first <= r2_first;
            r3_last  <= r2_last;
            r3_mask  <= r2_mask;
            r3_fg    <= r2_fg;
            r3_bg    <= r2_bg;
            r3_d     <= n3_d;

            r4_first <= r3_first;
            r4_last  <= r3_last;
            r4_mask  <= r3_mask;
            r4_fg    <= r3_fg;
            r4_bg    <= r3_bg;
            r4_err   <= n4_err;

            if (r4_v && w_better) begin
                r_best_err <= r4_err;
                r_best     <= w_cand;
            end
            if (r4_v && r4_last) begin
                r_out <= w_better ? w_cand : r_best;
            end
        end
    end

endmodule

// File: tb/tb_sextant_two_color_partition.sv
module tb_sextant_two_color_partition;
    import scp_pkg::*;

    // Expected partitions, oldest first; a class keeps the error count alongside.
    class partition_board;
        t_scp_out pending[$];
        int       n_err;
        int       n_seen;

        function new();
            n_err  = 0;
            n_seen = 0;
        endfunction

        // Exhaustive 64-mask search: truncated group means, squared RGB error,
        // lowest score wins, the lower mask on a tie.
        function void note_request(t_scp_in req);
            logic [23:0] col [6];
            logic [23:0] pick;
            logic [7:0]  ch;
            logic [7:0]  mf [3];
            logic [7:0]  mb [3];
            int          sf [3];
            int          sb [3];
            int          nf, nb, score, best, d;
            t_scp_out    win;

            if (req.opaque_flags == '0) return;
            col[0] = req.opaque_flags[0] ? req.px0_rgb : req.under_color;
            col[1] = req.opaque_flags[1] ? req.px1_rgb : req.under_color;
            col[2] = req.opaque_flags[2] ? req.px2_rgb : req.under_color;
            col[3] = req.opaque_flags[3] ? req.px3_rgb : req.under_color;
            col[4] = req.opaque_flags[4] ? req.px4_rgb : req.under_color;
            col[5] = req.opaque_flags[5] ? req.px5_rgb : req.under_color;
            best = -1;
            win  = '0;
            for (int m = 0; m < SCP_NUM_MASKS; m++) begin
                nf = 0;
                nb = 0;
                for (int k = 0; k < 3; k++) begin
                    sf[k] = 0;
                    sb[k] = 0;
                end
                for (int i = 0; i < SCP_NUM_SUB; i++) begin
                    for (int k = 0; k < 3; k++) begin
                        ch = col[i][8*k +: 8];
                        if (m[i]) sf[k] += ch;
                        else      sb[k] += ch;
                    end
                    if (m[i]) nf++;
                    else      nb++;
                end
                for (int k = 0; k < 3; k++) begin
                    mf[k] = (nf != 0) ? 8'(sf[k] / nf) : 8'd0;
                    mb[k] = (nb != 0) ? 8'(sb[k] / nb) : 8'd0;
                end
                score = 0;
                for (int i = 0; i < SCP_NUM_SUB; i++) begin
                    for (int k = 0; k < 3; k++) begin
                        d = int'(col[i][8*k +: 8]) - int'(m[i] ? mf[k] : mb[k]);
                        score += d * d;
                    end
                end
                if (best < 0 || score < best) begin
                    best = score;
                    win.glyph_mask = 6'(m);
                    win.fg_color   = {mf[2], mf[1], mf[0]};
                    win.bg_color   = {mb[2], mb[1], mb[0]};
                    // empty group copies the other mean
                    if (nf == 0) win.fg_color = win.bg_color;
                    if (nb == 0) win.bg_color = win.fg_color;
                end
            end
            pending.push_back(win);
        endfunction

        function void check_partition(t_scp_out got);
            t_scp_out exp_p;
            n_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected partition %h", $time, got);
                n_err++;
                return;
            end
            exp_p = pending.pop_front();
            if (got.glyph_mask !== exp_p.glyph_mask) begin
                $display("%0t: mask exp %h got %h", $time, exp_p.glyph_mask, got.glyph_mask);
                n_err++;
            end
            if (got.fg_color !== exp_p.fg_color) begin
                $display("%0t: fg exp %h got %h", $time, exp_p.fg_color, got.fg_color);
                n_err++;
            end
            if (got.bg_color !== exp_p.bg_color) begin
                $display("%0t: bg exp %h got %h", $time, exp_p.bg_color, got.bg_color);
                n_err++;
            end
        endfunction
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_scp_in  i_in = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_scp_out o_out;

    partition_board board = new();
    longint   n_cycles = 0;
    int       n_sent = 0;
    int       n_dropped = 0;
    bit       tx_done = 1'b0;

    // Worst case: ~1175 requests, each with a full mask search, a long gap and a long stall.
    localparam longint CYCLE_LIMIT = 1500000;

    always #4 i_clk = ~i_clk;

    sextant_two_color_partition u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Mostly short gaps, now and then a long one, often none.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Sample at the edge, judge with pre-edge values.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_partition(o_out);
        if (i_rst_n && i_in_valid && !o_in_stall) board.note_request(i_in);
    end

    // Receiver stall: bursts of random length, with quiet stretches.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = gap_len();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Present one request and hold it until taken.
    task automatic send_request(t_scp_in req);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        n_sent++;
        if (req.opaque_flags == '0) n_dropped++;
    endtask

    function automatic logic [23:0] rand_rgb();
        return 24'($urandom());
    endfunction

    // Two-tone cell: colors near one of two bases, so the search has a clear winner
    // and also close ties.
    function automatic t_scp_in two_tone_cell();
        t_scp_in     c;
        logic [23:0] base [2];
        logic [23:0] p [6];
        base[0] = rand_rgb();
        base[1] = rand_rgb();
        for (int i = 0; i < 6; i++) begin
            p[i] = base[$urandom_range(0, 1)];
            if ($urandom_range(0, 1)) p[i] ^= 24'($urandom_range(0, 7) * 24'h010101);
        end
        c.px0_rgb = p[0]; c.px1_rgb = p[1]; c.px2_rgb = p[2];
        c.px3_rgb = p[3]; c.px4_rgb = p[4]; c.px5_rgb = p[5];
        c.opaque_flags = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'h3f;
        c.under_color  = rand_rgb();
        return c;
    endfunction

    initial begin
        t_scp_in c;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all black, all white, nothing opaque, single opaque
        // subpixels, checkerboards, identical colors (tie to mask 0).
        c = '0; c.opaque_flags = 6'h3f;
        send_request(c);
        c = '1;
        send_request(c);
        c = '1; c.opaque_flags = '0;
        send_request(c);
        for (int i = 0; i < 6; i++) begin
            c = '0; c.under_color = 24'h102030;
            c.opaque_flags = 6'(1 << i);
            c.px0_rgb = 24'hffffff; c.px1_rgb = 24'hff0000; c.px2_rgb = 24'h00ff00;
            c.px3_rgb = 24'h0000ff; c.px4_rgb = 24'h808080; c.px5_rgb = 24'h7f7f7f;
            send_request(c);
        end
        c.opaque_flags = 6'h3f;
        c.px0_rgb = 24'hffffff; c.px1_rgb = 24'h000000; c.px2_rgb = 24'h000000;
        c.px3_rgb = 24'hffffff; c.px4_rgb = 24'hffffff; c.px5_rgb = 24'h000000;
        send_request(c);
        c.px0_rgb = 24'h000000; c.px1_rgb = 24'hffffff; c.px2_rgb = 24'hffffff;
        c.px3_rgb = 24'h000000; c.px4_rgb = 24'h000000; c.px5_rgb = 24'hffffff;
        send_request(c);
        c.px0_rgb = 24'h123456; c.px1_rgb = 24'h123456; c.px2_rgb = 24'h123456;
        c.px3_rgb = 24'h123456; c.px4_rgb = 24'h123456; c.px5_rgb = 24'h123456;
        send_request(c);
        c.opaque_flags = 6'h15; c.under_color = 24'hfefdfc;
        send_request(c);
        c.opaque_flags = 6'h2a; c.under_color = 24'h010203;
        send_request(c);

        // Random: mostly structured two-tone cells, some fully random,
        // a few with nothing opaque.
        for (int n = 0; n < 1160; n++) begin
            case ($urandom_range(0, 9))
                0: begin
                    c = two_tone_cell();
                    c.opaque_flags = '0;
                end
                1, 2, 3: begin
                    c.px0_rgb = rand_rgb(); c.px1_rgb = rand_rgb(); c.px2_rgb = rand_rgb();
                    c.px3_rgb = rand_rgb(); c.px4_rgb = rand_rgb(); c.px5_rgb = rand_rgb();
                    c.opaque_flags = 6'($urandom());
                    c.under_color  = rand_rgb();
                end
                default: c = two_tone_cell();
            endcase
            send_request(c);
        end
        i_in_valid <= 1'b0;
        tx_done = 1'b1;
    end

    initial begin
        wait (tx_done);
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("%0d cells sent (%0d with nothing opaque), %0d partitions checked",
                 n_sent, n_dropped, board.n_seen);
        if (board.n_err == 0) $display("simulation ok");
        else                  $display("simulation failed");
        $finish;
    end

    initial begin
        wait (n_cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", n_cycles);
        $display("simulation failed");
        $finish;
    end

endmodule
